@@ hdl/vir_pkg.sv @@
// Shared types, codes and lookup functions of the instruction record parser.
package vir_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC = 4'd0,
    PH_COUNT = 4'd1,
    PH_OP    = 4'd2,
    PH_MASK  = 4'd3,
    PH_A     = 4'd4,
    PH_B     = 4'd5,
    PH_C     = 4'd6,
    PH_TAG   = 4'd7,
    PH_F32   = 4'd8,
    PH_REF   = 4'd9,
    PH_AUX   = 4'd10
  } phase_t;

  localparam logic [3:0] ST_RECORD    = 4'd0;
  localparam logic [3:0] ST_EMPTY     = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_MAGIC     = 4'd3;
  localparam logic [3:0] ST_COUNT     = 4'd4;
  localparam logic [3:0] ST_TRUNC     = 4'd5;
  localparam logic [3:0] ST_OPND_A    = 4'd6;
  localparam logic [3:0] ST_OPND_B    = 4'd7;
  localparam logic [3:0] ST_OPND_C    = 4'd8;
  localparam logic [3:0] ST_TAG       = 4'd9;
  localparam logic [3:0] ST_F32       = 4'd10;
  localparam logic [3:0] ST_REF       = 4'd11;
  localparam logic [3:0] ST_TAG_VALUE = 4'd12;
  localparam logic [3:0] ST_AUX       = 4'd13;

  localparam logic [7:0] TAG_F32 = 8'h00;
  localparam logic [7:0] TAG_REF = 8'h01;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [5:0]  present_mask;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [31:0] angle_bits;
    logic [31:0] aux_word;
    logic [3:0]  status;
    logic        is_final;
  } result_t;

  // Up to two results per byte: the byte's own result, then an end-of-section error.
  typedef struct packed {
    logic    first_vld;
    logic    second_vld;
    result_t first;
    result_t second;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h49;
      2'd1: b = 8'h4E;
      2'd2: b = 8'h53;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Status reported when a section ends while the parser waits in a phase.
  function automatic logic [3:0] end_code(input phase_t ph);
    logic [3:0] c;
    unique case (ph)
      PH_MAGIC: c = ST_SHORT;
      PH_COUNT: c = ST_COUNT;
      PH_OP, PH_MASK: c = ST_TRUNC;
      PH_A:     c = ST_OPND_A;
      PH_B:     c = ST_OPND_B;
      PH_C:     c = ST_OPND_C;
      PH_TAG:   c = ST_TAG;
      PH_F32:   c = ST_F32;
      PH_REF:   c = ST_REF;
      PH_AUX:   c = ST_AUX;
      default:  c = ST_RECORD;
    endcase
    return c;
  endfunction

  function automatic result_t error_result(input logic [3:0] code);
    result_t r;
    r          = '0;
    r.status   = code;
    r.is_final = 1'b1;
    return r;
  endfunction

endpackage

@@ hdl/vir_core.sv @@
// Input register and byte-at-a-time parse state machine of the record parser.
module vir_core import vir_pkg::*; #(
  parameter int OPERAND_BITS = 32,
  parameter int COUNT_BITS   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_section_end,
  input  logic       room,
  output push_t      push
);

  localparam int OPW   = (OPERAND_BITS < 32) ? OPERAND_BITS : 32;
  localparam int ACC_W = (COUNT_BITS > OPW) ? COUNT_BITS : OPW;

  logic       iv_r, iv_nxt;
  logic [7:0] ib_r;
  logic       ie_r;
  logic       take, go;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          bc_r, bc_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [3:0]          sh_r, sh_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic [7:0]          opc_r, opc_nxt;
  logic [5:0]          mask_r, mask_nxt;
  logic [OPW-1:0]      opa_r, opa_nxt, opb_r, opb_nxt, opc3_r, opc3_nxt;
  logic [31:0]         ang_r, ang_nxt;
  logic [31:0]         aux_r, aux_nxt;
  logic                halted_r, halted_nxt;
  logic                mis_r, mis_nxt;

  logic [6:0]       sh_amt;
  logic [ACC_W-1:0] acc_fed;
  logic             vi_more, vi_ovf;
  logic             adv_go, err_go, found;
  logic [2:0]       adv_from, pj;
  logic [3:0]       err_code;
  push_t            push_d;

  assign take     = in_valid && in_ready;
  assign go       = iv_r && room;
  assign in_ready = !iv_r || room;
  assign iv_nxt   = take ? 1'b1 : (go ? 1'b0 : iv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ib_r <= in_data_byte;
      ie_r <= in_section_end;
    end
  end

  // ULEB128 step: 7 bits per byte, anything shifted past the accumulator is lost.
  assign sh_amt  = 7'(sh_r) * 7'd7;
  assign acc_fed = acc_r | (ACC_W'(ib_r[6:0]) << sh_amt);
  assign vi_more = ib_r[7] && (sh_r != 4'd9);
  assign vi_ovf  = ib_r[7] && (sh_r == 4'd9);

  always_comb begin
    phase_nxt  = phase_r;
    bc_nxt     = bc_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    left_nxt   = left_r;
    opc_nxt    = opc_r;
    mask_nxt   = mask_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    opc3_nxt   = opc3_r;
    ang_nxt    = ang_r;
    aux_nxt    = aux_r;
    halted_nxt = halted_r;
    mis_nxt    = mis_r;
    adv_go     = 1'b0;
    adv_from   = 3'd0;
    err_go     = 1'b0;
    err_code   = ST_RECORD;
    found      = 1'b0;
    pj         = 3'd0;
    push_d     = '0;

    if (!halted_r) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (ib_r != magic_byte(bc_r[1:0])) mis_nxt = 1'b1;
          bc_nxt = bc_r + 3'd1;
          if (bc_nxt[2]) begin
            if (mis_nxt) begin
              err_go   = 1'b1;
              err_code = ST_MAGIC;
            end else begin
              phase_nxt = PH_COUNT;
              acc_nxt   = '0;
              sh_nxt    = '0;
            end
          end
        end
        PH_COUNT: begin
          acc_nxt = acc_fed;
          if (vi_ovf) begin
            err_go   = 1'b1;
            err_code = ST_COUNT;
          end else if (vi_more) begin
            sh_nxt = sh_r + 4'd1;
          end else begin
            left_nxt = acc_fed[COUNT_BITS-1:0];
            if (left_nxt == '0) begin
              err_go   = 1'b1;
              err_code = ST_EMPTY;
            end else begin
              phase_nxt = PH_OP;
            end
          end
        end
        PH_OP: begin
          opc_nxt   = ib_r;
          opa_nxt   = '0;
          opb_nxt   = '0;
          opc3_nxt  = '0;
          ang_nxt   = '0;
          aux_nxt   = '0;
          phase_nxt = PH_MASK;
        end
        PH_MASK: begin
          // Mask bit 7 selects the aux word; bits 4 to 6 are unused.
          mask_nxt = {1'b0, ib_r[7], ib_r[3:0]};
          adv_go   = 1'b1;
          adv_from = 3'd0;
        end
        PH_A, PH_B, PH_C: begin
          acc_nxt = acc_fed;
          if (vi_ovf) begin
            err_go   = 1'b1;
            err_code = (phase_r == PH_A) ? ST_OPND_A :
                       (phase_r == PH_B) ? ST_OPND_B : ST_OPND_C;
          end else if (vi_more) begin
            sh_nxt = sh_r + 4'd1;
          end else begin
            adv_go = 1'b1;
            if (phase_r == PH_A) begin
              opa_nxt  = acc_fed[OPW-1:0];
              adv_from = 3'd1;
            end else if (phase_r == PH_B) begin
              opb_nxt  = acc_fed[OPW-1:0];
              adv_from = 3'd2;
            end else begin
              opc3_nxt = acc_fed[OPW-1:0];
              adv_from = 3'd3;
            end
          end
        end
        PH_TAG: begin
          if (ib_r == TAG_F32) begin
            phase_nxt = PH_F32;
            bc_nxt    = '0;
          end else if (ib_r == TAG_REF) begin
            phase_nxt = PH_REF;
            acc_nxt   = '0;
            sh_nxt    = '0;
          end else begin
            err_go   = 1'b1;
            err_code = ST_TAG_VALUE;
          end
        end
        PH_F32: begin
          ang_nxt = ang_r | (32'(ib_r) << {bc_r[1:0], 3'b000});
          bc_nxt  = bc_r + 3'd1;
          if (bc_nxt[2]) begin
            adv_go   = 1'b1;
            adv_from = 3'd4;
          end
        end
        PH_REF: begin
          acc_nxt = acc_fed;
          if (vi_ovf) begin
            err_go   = 1'b1;
            err_code = ST_REF;
          end else if (vi_more) begin
            sh_nxt = sh_r + 4'd1;
          end else begin
            mask_nxt = mask_r | 6'h20;
            ang_nxt  = '0;
            adv_go   = 1'b1;
            adv_from = 3'd4;
          end
        end
        PH_AUX: begin
          aux_nxt = aux_r | (32'(ib_r) << {bc_r[1:0], 3'b000});
          bc_nxt  = bc_r + 3'd1;
          if (bc_nxt[2]) begin
            adv_go   = 1'b1;
            adv_from = 3'd5;
          end
        end
        default: begin
          halted_nxt = 1'b1;
        end
      endcase

      // Move to the next present field, or close the record if none is left.
      if (adv_go) begin
        for (int j = 4; j >= 0; j--) begin
          if ((3'(j) >= adv_from) && mask_nxt[j]) begin
            found = 1'b1;
            pj    = 3'(j);
          end
        end
        if (found) begin
          unique case (pj)
            3'd0: phase_nxt = PH_A;
            3'd1: phase_nxt = PH_B;
            3'd2: phase_nxt = PH_C;
            3'd3: phase_nxt = PH_TAG;
            default: phase_nxt = PH_AUX;
          endcase
          bc_nxt  = '0;
          acc_nxt = '0;
          sh_nxt  = '0;
        end else begin
          left_nxt                  = left_r - COUNT_BITS'(1);
          push_d.first_vld          = 1'b1;
          push_d.first.opcode       = opc_nxt;
          push_d.first.present_mask = mask_nxt;
          push_d.first.operand_a    = 32'(opa_nxt);
          push_d.first.operand_b    = 32'(opb_nxt);
          push_d.first.operand_c    = 32'(opc3_nxt);
          push_d.first.angle_bits   = ang_nxt;
          push_d.first.aux_word     = aux_nxt;
          push_d.first.status       = ST_RECORD;
          push_d.first.is_final     = (left_nxt == '0);
          if (left_nxt == '0) halted_nxt = 1'b1;
          else phase_nxt = PH_OP;
        end
      end

      if (err_go) begin
        push_d.first_vld = 1'b1;
        push_d.first     = error_result(err_code);
        halted_nxt       = 1'b1;
      end
    end

    if (ie_r) begin
      if (!halted_nxt) begin
        push_d.second_vld = 1'b1;
        push_d.second     = error_result(end_code(phase_nxt));
      end
      phase_nxt  = PH_MAGIC;
      bc_nxt     = '0;
      acc_nxt    = '0;
      sh_nxt     = '0;
      halted_nxt = 1'b0;
      mis_nxt    = 1'b0;
    end
  end

  always_comb begin
    push = push_d;
    if (!go) begin
      push.first_vld  = 1'b0;
      push.second_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      bc_r     <= '0;
      acc_r    <= '0;
      sh_r     <= '0;
      halted_r <= 1'b0;
      mis_r    <= 1'b0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      acc_r    <= acc_nxt;
      sh_r     <= sh_nxt;
      halted_r <= halted_nxt;
      mis_r    <= mis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      left_r <= left_nxt;
      opc_r  <= opc_nxt;
      mask_r <= mask_nxt;
      opa_r  <= opa_nxt;
      opb_r  <= opb_nxt;
      opc3_r <= opc3_nxt;
      ang_r  <= ang_nxt;
      aux_r  <= aux_nxt;
    end
  end

  a_second_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    push.second_vld |-> (push.second.is_final && push.second.status != ST_RECORD))
    else $error("end-of-section result is not a final error");

  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (go && ie_r) |=> (phase_r == PH_MAGIC && !halted_r && bc_r == 3'd0))
    else $error("section end did not rearm the parser");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (go && halted_r) |-> !push.first_vld)
    else $error("result produced while halted");

endmodule

@@ hdl/vir_outq.sv @@
// Four-entry result queue that takes up to two results per cycle while room is set.
module vir_outq import vir_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  localparam int DEPTH = 4;

  result_t    mem_r [DEPTH];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] npush;
  logic       pop;

  assign npush     = 2'(push.first_vld) + 2'(push.second_vld);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rp_r];
  // Room for two more results is checked before this cycle's pop.
  assign room      = (cnt_r <= 3'(DEPTH - 2));
  assign wp_nxt    = wp_r + npush;
  assign rp_nxt    = rp_r + 2'(pop);
  assign cnt_nxt   = cnt_r + 3'(npush) - 3'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem_r[wp_r] <= push.first;
    end else if (push.second_vld) begin
      mem_r[wp_r] <= push.second;
    end
    if (push.first_vld && push.second_vld) begin
      mem_r[wp_r + 2'd1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.first_vld || push.second_vld) |-> (cnt_r <= 3'(DEPTH - 2)))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH))
    else $error("result queue count out of range");

endmodule

@@ hdl/varint_instruction_record_parser.sv @@
// Top level of the streaming instruction record parser.
// Usage:
//   The input channel carries one section byte per request, with
//   in_section_end set on the last byte of a section. The parser checks the
//   "INST" magic, reads a ULEB128 record count and then decodes records.
//   The output channel carries one request per finished record or error;
//   out_is_final marks the last record, an empty section or an error.
//   A byte may produce two results (a record and an end-of-section error).
// Timing:
//   One byte is taken per cycle while in_ready is high. A byte is held in the
//   input register, and its results are parsed from there and written into a
//   four-entry result queue, whose head is offered on the output channel.
//   A byte leaves the input register only while the queue has room for two
//   results; otherwise the register holds it and in_ready drops.
// Reset and stalls:
//   rst_n is synchronous, active low; it empties the queue and rearms the
//   parser to wait for the magic. When the receiver stalls, results wait in
//   the queue and input bytes keep flowing until the queue is nearly full.
module varint_instruction_record_parser import vir_pkg::*; #(
  parameter int OPERAND_BITS = 32,
  parameter int COUNT_BITS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_section_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_opcode,
  output logic [5:0]  out_present_mask,
  output logic [31:0] out_operand_a,
  output logic [31:0] out_operand_b,
  output logic [31:0] out_operand_c,
  output logic [31:0] out_angle_bits,
  output logic [31:0] out_aux_word,
  output logic [3:0]  out_status,
  output logic        out_is_final
);

  push_t   push;
  logic    room;
  result_t head;

  vir_core #(
    .OPERAND_BITS(OPERAND_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_section_end(in_section_end),
    .room          (room),
    .push          (push)
  );

  vir_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_opcode       = head.opcode;
  assign out_present_mask = head.present_mask;
  assign out_operand_a    = head.operand_a;
  assign out_operand_b    = head.operand_b;
  assign out_operand_c    = head.operand_c;
  assign out_angle_bits   = head.angle_bits;
  assign out_aux_word     = head.aux_word;
  assign out_status       = head.status;
  assign out_is_final     = head.is_final;

endmodule
